@@ rtl/lru_page_replacement_top_assert.svh @@
// Assertion macros for the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define LRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru assertion failed");

`endif

@@ rtl/lru_pkg.sv @@
`default_nettype none

package lru_pkg;

    // Default number of stack entries
    localparam int MAX_FRAMES_DEF = 8;

    // Field widths
    localparam int PAGE_W   = 16;
    localparam int POS_W    = 3;
    localparam int COUNT_W  = 16;
    localparam int FRAMES_W = 4;

    // Output tdata layout, lowest bit up
    localparam int OUT_HIT_LSB   = 0;
    localparam int OUT_POS_LSB   = OUT_HIT_LSB + 1;
    localparam int OUT_EVV_LSB   = OUT_POS_LSB + POS_W;
    localparam int OUT_EVP_LSB   = OUT_EVV_LSB + 1;
    localparam int OUT_FAULT_LSB = OUT_EVP_LSB + PAGE_W;
    localparam int OUT_BITS      = OUT_FAULT_LSB + COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd8;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [POS_W-1:0]    POS_MAX      = {POS_W{1'b1}};

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture input transfer
        logic lookup;   // register compare vector
        logic commit;   // update stack, load output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_blocked;  // output register full and not being taken
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/lru_ctrl.sv @@
`default_nettype none

module lru_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lru_pkg::stat_t stat,
    output lru_pkg::cmd_t      cmd
);

    lru_pkg::state_t state_reg;
    lru_pkg::state_t state_next;
    logic            commit_ok;

    // Commit once the output register can take the result
    assign commit_ok = (state_reg == lru_pkg::ST_UPDATE) && !stat.out_blocked;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = lru_pkg::ST_LOOKUP;
            end
            lru_pkg::ST_LOOKUP:
            begin
                state_next = lru_pkg::ST_UPDATE;
            end
            lru_pkg::ST_UPDATE:
            begin
                if (commit_ok)
                    state_next = in_valid ? lru_pkg::ST_LOOKUP : lru_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            lru_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            lru_pkg::ST_UPDATE:
            begin
                // next item may enter as this one retires
                cmd.commit = commit_ok;
                in_ready   = commit_ok;
                cmd.load   = commit_ok && in_valid;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lru_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ rtl/lru_dpath.sv @@
`default_nettype none

module lru_dpath #(
    parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lru_pkg::cmd_t                    cmd,
    output lru_pkg::stat_t                        stat,
    input  wire logic                             cfg_wen,
    input  wire logic [lru_pkg::FRAMES_W-1:0]     cfg_wdata,
    input  wire logic [lru_pkg::PAGE_W-1:0]       in_page,
    input  wire logic                             in_last,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [lru_pkg::OUT_TDATA_W-1:0]       out_data
);

    localparam int FILL_W = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CMP_W  = (FILL_W > lru_pkg::FRAMES_W) ? FILL_W : lru_pkg::FRAMES_W;
    localparam int PAD_W  = lru_pkg::OUT_TDATA_W - lru_pkg::OUT_BITS;

    // Stack entries: entry 0 is the most recent page
    logic [lru_pkg::PAGE_W-1:0]   stack_reg [MAX_FRAMES];
    logic [lru_pkg::PAGE_W-1:0]   page_reg;
    logic                         last_reg;
    logic [MAX_FRAMES-1:0]        match_reg;
    logic [FILL_W-1:0]            fill_reg;
    logic [FILL_W-1:0]            fill_next;
    logic [lru_pkg::COUNT_W-1:0]  fault_reg;
    logic [lru_pkg::COUNT_W-1:0]  fault_next;
    logic [lru_pkg::FRAMES_W-1:0] frames_reg;
    logic                         out_valid_reg;
    logic [lru_pkg::OUT_BITS-1:0] out_data_reg;

    logic [CMP_W-1:0]             frames_ext;
    logic [FILL_W-1:0]            eff;
    logic [FILL_W-1:0]            ev_idx;
    logic                         found;
    logic [IDX_W-1:0]             depth;
    logic                         full;
    logic [FILL_W-1:0]            kept;
    logic [IDX_W-1:0]             limit;
    logic [lru_pkg::POS_W-1:0]    hit_pos;
    logic [lru_pkg::PAGE_W-1:0]   ev_page;

    // Effective frame count, clamped to 1..MAX_FRAMES
    assign frames_ext = CMP_W'(frames_reg);
    always_comb
    begin
        if (frames_ext == '0)
            eff = FILL_W'(1);
        else if (frames_ext > CMP_W'(MAX_FRAMES))
            eff = FILL_W'(MAX_FRAMES);
        else
            eff = FILL_W'(frames_ext);
    end

    // Shallowest matching entry
    always_comb
    begin
        depth = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                depth = IDX_W'(i);
        end
    end
    assign found = |match_reg;

    // Miss handling: evict the bottom entry within the frame count when full
    assign full    = (fill_reg >= eff);
    assign kept    = full ? (eff - FILL_W'(1)) : fill_reg;
    assign ev_idx  = eff - FILL_W'(1);
    assign ev_page = (!found && full) ? stack_reg[ev_idx[IDX_W-1:0]] : '0;
    assign limit   = found ? depth : kept[IDX_W-1:0];
    assign hit_pos = !found ? '0 :
                     (IDX_W > lru_pkg::POS_W && depth > IDX_W'(lru_pkg::POS_MAX)) ?
                     lru_pkg::POS_MAX : lru_pkg::POS_W'(depth);

    // Counters after this reference
    always_comb
    begin
        fill_next  = found ? fill_reg : (kept + FILL_W'(1));
        fault_next = fault_reg;
        if (!found && fault_reg != lru_pkg::COUNT_MAX)
            fault_next = fault_reg + lru_pkg::COUNT_W'(1);
    end

    // Control state: counters, configuration, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            fault_reg     <= '0;
            frames_reg    <= lru_pkg::FRAMES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                frames_reg <= cfg_wdata;
            if (cmd.commit)
            begin
                fill_reg  <= last_reg ? '0 : fill_next;
                fault_reg <= last_reg ? '0 : fault_next;
            end
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: input capture, compare vector, stack shift, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= in_page;
            last_reg <= in_last;
        end
        if (cmd.lookup)
        begin
            for (int i = 0; i < MAX_FRAMES; i++)
                match_reg[i] <= (stack_reg[i] == page_reg) && (FILL_W'(i) < fill_reg);
        end
        if (cmd.commit)
        begin
            for (int i = 1; i < MAX_FRAMES; i++)
            begin
                if (IDX_W'(i) <= limit)
                    stack_reg[i] <= stack_reg[i-1];
            end
            stack_reg[0] <= page_reg;
            out_data_reg <= {fault_next, ev_page, (!found && full), hit_pos, found};
        end
    end

    assign stat.out_blocked = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;

    generate
        if (PAD_W > 0)
        begin : g_pad
            assign out_data = {{PAD_W{1'b0}}, out_data_reg};
        end
        else
        begin : g_nopad
            assign out_data = out_data_reg;
        end
    endgenerate

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement_top.sv @@
// Channel   Direction  Signals                            Content
// s_axis    in         tvalid tready tdata[15:0] tlast    page_number, last_reference
// m_axis    out        tvalid tready tdata[39:0]          one result per reference
// cfg       in         cfg_wen cfg_wdata[3:0]             frames_in_use
//
// Each reference is compared against every stack entry in a lookup step, then
// an update step shifts the stack and loads the output register.
// The next reference is taken in the cycle its predecessor retires.
// A result stalled on m_axis holds back only the retiring step.
// rst_n clears fill count, fault counter and output valid; frames reset to 8.
`default_nettype none

module lru_page_replacement_top #(
    parameter int MAX_FRAMES = lru_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [15:0] page_number
    input  wire logic [lru_pkg::PAGE_W-1:0]            s_axis_tdata,
    input  wire logic                                  s_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] hit, [3:1] hit_position, [4] evicted_valid, [20:5] evicted_page,
    // [36:21] fault_count, [39:37] zero
    output logic [lru_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    input  wire logic                                  cfg_wen,
    input  wire logic [lru_pkg::FRAMES_W-1:0]          cfg_wdata
);

    lru_pkg::cmd_t  cmd;
    lru_pkg::stat_t stat;

    lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lru_dpath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_page   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/lru_chk.sv @@
`default_nettype none

`include "lru_page_replacement_top_assert.svh"

module lru_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [lru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic in_xfer;
    logic out_stall;
    logic hit;
    logic evicted;
    logic [lru_pkg::POS_W-1:0] pos;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign hit       = m_axis_tdata[lru_pkg::OUT_HIT_LSB];
    assign evicted   = m_axis_tdata[lru_pkg::OUT_EVV_LSB];
    assign pos       = m_axis_tdata[lru_pkg::OUT_POS_LSB +: lru_pkg::POS_W];

    // Stalled result holds
    `LRU_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // A reference needs its lookup cycle before the next one is taken
    `LRU_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready)
    // A hit never evicts
    `LRU_ASSERT_NOW(a_hit_no_evict, m_axis_tvalid && hit, !evicted)
    // A fault reports depth zero
    `LRU_ASSERT_NOW(a_miss_pos_zero, m_axis_tvalid && !hit, pos == '0)

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
    import lru_pkg::*;

    // Cycles without any transfer before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    // Pool of pages that one reference string draws from
    localparam int POOL_DEPTH  = 12;

    // One result transfer, split into its fields
    typedef struct packed {
        logic                hit;
        logic [POS_W-1:0]    position;
        logic                ev_valid;
        logic [PAGE_W-1:0]   ev_page;
        logic [COUNT_W-1:0]  faults;
    } lru_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // [15:0] page_number
    logic [PAGE_W-1:0]       s_axis_tdata;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [0] hit, [3:1] hit_position, [4] evicted_valid, [20:5] evicted_page,
    // [36:21] fault_count, [39:37] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_wen;
    logic [FRAMES_W-1:0]     cfg_wdata;

    // Mirror of the replacement stack
    logic [PAGE_W-1:0]       recency_stack [MAX_FRAMES_DEF];
    int                      resident_count;
    logic [COUNT_W-1:0]      fault_total;
    logic [FRAMES_W-1:0]     frames_setting;

    lru_result_t             pending_results [$];
    lru_result_t             oldest_result;
    int                      error_count;
    int                      stall_cycles;
    int                      src_idle_pct;
    int                      snk_idle_pct;

    lru_page_replacement_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one accepted reference and update the mirror
    task automatic lru_predict(input logic [PAGE_W-1:0] page, input logic last_ref);
        lru_result_t r;
        int eff;
        int fill;
        int depth;
        int kept;
        int i;
        bit found;
        eff = int'(frames_setting);
        if (eff < 1) eff = 1;
        if (eff > MAX_FRAMES_DEF) eff = MAX_FRAMES_DEF;
        fill = resident_count;
        found = 1'b0;
        depth = 0;
        r = '0;
        for (i = 0; i < fill; i++)
        begin
            if (!found && recency_stack[i] == page)
            begin
                found = 1'b1;
                depth = i;
            end
        end
        if (found)
        begin
            // hit: move to top, fill unchanged even beyond a shrunk size
            for (i = depth; i > 0; i--) recency_stack[i] = recency_stack[i-1];
            recency_stack[0] = page;
            r.hit = 1'b1;
            r.position = (depth > 7) ? POS_MAX : POS_W'(depth);
        end
        else
        begin
            // miss: evict the bottom within the current size when full
            if (fill >= eff)
            begin
                r.ev_valid = 1'b1;
                r.ev_page = recency_stack[eff-1];
                kept = eff - 1;
            end
            else
            begin
                kept = fill;
            end
            for (i = kept; i > 0; i--) recency_stack[i] = recency_stack[i-1];
            recency_stack[0] = page;
            fill = kept + 1;
            if (fault_total != COUNT_MAX) fault_total++;
        end
        resident_count = fill;
        r.faults = fault_total;
        pending_results.push_back(r);
        // end of string clears after the result is formed
        if (last_ref)
        begin
            resident_count = 0;
            fault_total = '0;
        end
    endtask

    // Drive one reference and wait for its transfer
    task automatic send_ref(input logic [PAGE_W-1:0] page, input logic last_ref);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tlast  <= last_ref;
        do @(posedge clk); while (!s_axis_tready);
        lru_predict(page, last_ref);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only while the block is quiet
    task automatic write_frames(input logic [FRAMES_W-1:0] value);
        settle_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        frames_setting = value;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    // Result checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("result transfer with nothing expected: %0h", m_axis_tdata);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("hit", 32'(oldest_result.hit),
                            32'(m_axis_tdata[OUT_HIT_LSB]));
                check_field("hit_position", 32'(oldest_result.position),
                            32'(m_axis_tdata[OUT_POS_LSB +: POS_W]));
                check_field("evicted_valid", 32'(oldest_result.ev_valid),
                            32'(m_axis_tdata[OUT_EVV_LSB]));
                check_field("evicted_page", 32'(oldest_result.ev_page),
                            32'(m_axis_tdata[OUT_EVP_LSB +: PAGE_W]));
                check_field("fault_count", 32'(oldest_result.faults),
                            32'(m_axis_tdata[OUT_FAULT_LSB +: COUNT_W]));
            end
        end
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Watchdog on cycles without a transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Reset-default frames: fill, deep hit, evictions, end of string
    task automatic test_directed_reference();
        int n;
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        for (n = 1; n <= 6; n++) send_ref(PAGE_W'(n), 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h5555, 1'b1);
    endtask

    // Frames register at zero (one frame) and above the stack size
    task automatic test_frame_limits();
        int n;
        write_frames(4'd0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h4321, 1'b0);
        send_ref(16'h4321, 1'b1);
        write_frames(4'd15);
        for (n = 0; n < 9; n++) send_ref(16'h8000 + PAGE_W'(n), n == 8);
    endtask

    // Shrinking the frames while pages are resident
    task automatic test_frame_shrink();
        int n;
        write_frames(4'd8);
        for (n = 0; n < 5; n++) send_ref(16'h0100 + PAGE_W'(n), 1'b0);
        write_frames(4'd2);
        send_ref(16'h0100, 1'b0);
        send_ref(16'h0200, 1'b0);
        send_ref(16'h0103, 1'b1);
    endtask

    // Random reference strings over a small working set, three idling phases
    task automatic test_random_strings();
        logic [PAGE_W-1:0] page_pool [POOL_DEPTH];
        logic [PAGE_W-1:0] page;
        logic last_ref;
        int pool_size;
        int phase;
        int n;
        int k;
        for (phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 45 : 0;
            snk_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 32 : 0;
            pool_size = 0;
            for (n = 0; n < 550; n++)
            begin
                if (n % 110 == 0)
                begin
                    write_frames(FRAMES_W'($urandom_range(0, 15)));
                    pool_size = 0;
                end
                // fresh working set at the start of each string
                if (pool_size == 0)
                begin
                    pool_size = $urandom_range(1, POOL_DEPTH);
                    for (k = 0; k < POOL_DEPTH; k++) page_pool[k] = PAGE_W'($urandom());
                end
                if ($urandom_range(0, 99) < 88)
                    page = page_pool[$urandom_range(0, pool_size - 1)];
                else
                    page = PAGE_W'($urandom());
                last_ref = ($urandom_range(0, 39) == 0);
                send_ref(page, last_ref);
                if (last_ref) pool_size = 0;
            end
        end
        settle_idle();
    endtask

    // Sequencer
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        error_count    = 0;
        resident_count = 0;
        fault_total    = '0;
        frames_setting = FRAMES_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reference();
        test_frame_limits();
        test_frame_shrink();
        test_random_strings();

        // drain, then a margin for any stray result
        settle_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
